>>> src/tmcw_pkg.sv
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared codes, widths and types of the text mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int PHASE_W = 4;
  localparam int CHAR_W  = 8;
  localparam int ATTR_W  = 8;
  localparam int CELL_W  = ATTR_W + CHAR_W;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] REG_COLUMNS   = 2'd0;
  localparam logic [1:0] REG_ROWS      = 2'd1;
  localparam logic [1:0] REG_SCROLL    = 2'd2;
  localparam logic [1:0] REG_ATTRIBUTE = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CHAR_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [PHASE_W-1:0] phase;
    logic [CHAR_W-1:0]  char_code;
    logic [COL_W-1:0]   cols;
    logic [ROW_W-1:0]   rows;
    logic               scroll_en;
  } cursor_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [PHASE_W-1:0] phase;
    logic               put;
    logic               scroll;
  } cursor_out_t;

endpackage

>>> src/tmcw_ram.sv
// ----------------------------------------------------------------------------
// tmcw_ram
// Generic simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/tmcw_cursor.sv
// ----------------------------------------------------------------------------
// tmcw_cursor
// Cursor update for one character byte: control codes, advance and bounds.
// ----------------------------------------------------------------------------
module tmcw_cursor import tmcw_pkg::*; #(
  parameter int TAB_STOP = 8
) (
  input  cursor_in_t  cur_in,
  output cursor_out_t cur_out
);

  localparam int RX_W = ROW_W + 1;
  localparam int CX_W = COL_W + 1;

  logic [RX_W-1:0]    r;
  logic [CX_W-1:0]    c;
  logic [PHASE_W-1:0] ph;
  logic               chk;
  logic               put;
  logic               scr;

  always_comb begin
    r   = {1'b0, cur_in.row};
    c   = {1'b0, cur_in.col};
    ph  = cur_in.phase;
    chk = 1'b1;
    put = 1'b0;
    scr = 1'b0;
    unique case (cur_in.char_code)
      CHAR_LF: begin
        r  = r + RX_W'(1);
        c  = '0;
        ph = '0;
      end
      CHAR_VT, CHAR_FF: begin
        r = r + RX_W'(1);
      end
      CHAR_CR: begin
        c   = '0;
        ph  = '0;
        chk = 1'b0;
      end
      CHAR_TAB: begin
        c  = c + CX_W'(TAB_STOP) - CX_W'(ph);
        ph = '0;
      end
      default: begin
        put = 1'b1;
        c   = c + CX_W'(1);
        ph  = (ph == PHASE_W'(TAB_STOP - 1)) ? '0 : ph + PHASE_W'(1);
      end
    endcase
    if (chk) begin
      if (c >= {1'b0, cur_in.cols}) begin
        r  = r + RX_W'(1);
        c  = '0;
        ph = '0;
      end
      if (r >= {1'b0, cur_in.rows}) begin
        if (cur_in.scroll_en) begin
          r   = {1'b0, cur_in.rows - ROW_W'(1)};
          scr = 1'b1;
        end else begin
          r = '0;
        end
      end
    end
  end

  assign cur_out.row    = r[ROW_W-1:0];
  assign cur_out.col    = c[COL_W-1:0];
  assign cur_out.phase  = ph;
  assign cur_out.put    = put;
  assign cur_out.scroll = scr;

endmodule

>>> src/text_mode_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit
// A character or control byte is handled in the execute state; its result is
// registered there unless the output is full or a scroll follows. A cell read
// passes the read and done states; a clear or a scroll walks the single RAM
// port cell by cell before the done state. One request is in work at a time;
// the result register frees the input side.
// Reset clears the cursor, loads the register defaults 80, 25, 0 and 7, and
// leaves the screen memory unwritten.
// ----------------------------------------------------------------------------
module text_mode_console_writer_unit import tmcw_pkg::*; #(
  parameter int MAX_COLUMNS = 80,
  parameter int MAX_ROWS    = 25,
  parameter int TAB_STOP    = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               write_enable,
  input  logic [1:0]         write_index,
  input  logic [7:0]         write_data,
  input  logic               request_valid,
  output logic               request_ready,
  input  logic [1:0]         mode,
  input  logic [CHAR_W-1:0]  char_code,
  input  logic [10:0]        read_index,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [CELL_W-1:0]  cell_entry,
  output logic [ROW_W-1:0]   cursor_row,
  output logic [COL_W-1:0]   cursor_col,
  output logic               scrolled
);

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int AW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int PW         = $clog2(CELL_COUNT + 1);
  localparam int PROD_W     = ROW_W + COL_W;
  localparam int SUM_W      = PROD_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_SCR_SET, ST_SCR_RD, ST_SCR_WR,
    ST_BLANK_SET, ST_BLANK, ST_READ, ST_DONE
  } state_t;

  state_t             state;
  logic [1:0]         req_mode;
  logic [CHAR_W-1:0]  req_char;
  logic [10:0]        req_index;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic [PHASE_W-1:0] phase;
  logic [PW-1:0]      ptr;
  logic [PW-1:0]      limit;
  logic [CELL_W-1:0]  res_cell;
  logic               res_scrolled;

  logic [COL_W-1:0]   screen_columns;
  logic [ROW_W-1:0]   screen_rows;
  logic               scroll_enable;
  logic [ATTR_W-1:0]  text_attribute;

  logic [COL_W-1:0]   cols_eff;
  logic [ROW_W-1:0]   rows_eff;
  logic [ROW_W-1:0]   mult_a;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   put_addr;
  logic               put_in_range;
  logic               read_in_range;
  logic [PW-1:0]      src;
  logic [PW-1:0]      ptr_inc;
  logic               out_free;
  logic               result_load;

  cursor_in_t         cur_in;
  cursor_out_t        cur_out;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_columns <= 7'd80;
      screen_rows    <= 5'd25;
      scroll_enable  <= 1'b0;
      text_attribute <= 8'd7;
    end else if (write_enable) begin
      unique case (write_index)
        REG_COLUMNS:   screen_columns <= write_data[COL_W-1:0];
        REG_ROWS:      screen_rows    <= write_data[ROW_W-1:0];
        REG_SCROLL:    scroll_enable  <= write_data[0];
        REG_ATTRIBUTE: text_attribute <= write_data[ATTR_W-1:0];
      endcase
    end
  end

  // clamped geometry
  always_comb begin
    if (screen_columns == '0) begin
      cols_eff = COL_W'(1);
    end else if ({1'b0, screen_columns} > 8'(MAX_COLUMNS)) begin
      cols_eff = COL_W'(MAX_COLUMNS);
    end else begin
      cols_eff = screen_columns;
    end
    if (screen_rows == '0) begin
      rows_eff = ROW_W'(1);
    end else if ({3'b000, screen_rows} > 8'(MAX_ROWS)) begin
      rows_eff = ROW_W'(MAX_ROWS);
    end else begin
      rows_eff = screen_rows;
    end
  end

  // shared multiplier and address adders
  always_comb begin
    priority if (state == ST_SCR_SET) begin
      mult_a = rows_eff - ROW_W'(1);
    end else if (req_mode == MODE_CLEAR) begin
      mult_a = rows_eff;
    end else begin
      mult_a = row;
    end
  end

  assign prod          = PROD_W'(mult_a) * PROD_W'(cols_eff);
  assign put_addr      = SUM_W'(prod) + SUM_W'(col);
  assign put_in_range  = 32'(put_addr) < 32'(CELL_COUNT);
  assign read_in_range = 32'(req_index) < 32'(CELL_COUNT);
  assign src           = ptr + PW'(cols_eff);
  assign ptr_inc       = ptr + PW'(1);
  assign out_free      = !result_valid || result_ready;
  assign result_load   = out_free &&
                         ((state == ST_EXEC && req_mode == MODE_WRITE && !cur_out.scroll) ||
                          state == ST_DONE);

  assign cur_in.row       = row;
  assign cur_in.col       = col;
  assign cur_in.phase     = phase;
  assign cur_in.char_code = req_char;
  assign cur_in.cols      = cols_eff;
  assign cur_in.rows      = rows_eff;
  assign cur_in.scroll_en = scroll_enable;

  tmcw_cursor #(
    .TAB_STOP (TAB_STOP)
  ) u_cursor (
    .cur_in  (cur_in),
    .cur_out (cur_out)
  );

  // screen memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr[AW-1:0];
    ram_wdata = {text_attribute, CHAR_BLANK};
    ram_raddr = src[AW-1:0];
    case (state)
      ST_EXEC: begin
        if (req_mode == MODE_WRITE && cur_out.put && put_in_range) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(put_addr);
          ram_wdata = {text_attribute, req_char};
        end
        if (req_mode == MODE_READ) begin
          ram_raddr = AW'(req_index);
        end
      end
      ST_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      ST_BLANK: begin
        ram_we = 1'b1;
      end
      default: ;
    endcase
  end

  tmcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign request_ready = (state == ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      row          <= '0;
      col          <= '0;
      phase        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (request_valid) begin
            req_mode  <= mode;
            req_char  <= char_code;
            req_index <= read_index;
            state     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_cell     <= '0;
          res_scrolled <= (req_mode == MODE_WRITE) && cur_out.scroll;
          unique case (req_mode)
            MODE_WRITE: begin
              row   <= cur_out.row;
              col   <= cur_out.col;
              phase <= cur_out.phase;
              if (cur_out.scroll) begin
                state <= ST_SCR_SET;
              end else if (out_free) begin
                cell_entry <= '0;
                cursor_row <= cur_out.row;
                cursor_col <= cur_out.col;
                scrolled   <= 1'b0;
                state      <= ST_IDLE;
              end else begin
                state <= ST_DONE;
              end
            end
            MODE_CLEAR: begin
              ptr   <= '0;
              limit <= PW'(prod);
              state <= ST_BLANK;
            end
            MODE_READ: begin
              state <= ST_READ;
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end
        ST_SCR_SET: begin
          ptr <= '0;
          if (rows_eff == ROW_W'(1)) begin
            state <= ST_BLANK_SET;
          end else begin
            limit <= PW'(prod);
            state <= ST_SCR_RD;
          end
        end
        ST_SCR_RD: begin
          state <= ST_SCR_WR;
        end
        ST_SCR_WR: begin
          ptr <= ptr_inc;
          if (ptr_inc == limit) begin
            state <= ST_BLANK_SET;
          end else begin
            state <= ST_SCR_RD;
          end
        end
        ST_BLANK_SET: begin
          limit <= src;
          state <= ST_BLANK;
        end
        ST_BLANK: begin
          ptr <= ptr_inc;
          if (ptr_inc == limit) begin
            state <= ST_DONE;
          end
        end
        ST_READ: begin
          res_cell <= read_in_range ? ram_rdata : '0;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            cell_entry <= res_cell;
            cursor_row <= row;
            cursor_col <= col;
            scrolled   <= res_scrolled;
            state      <= ST_IDLE;
          end
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_blank_in_bounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_BLANK |-> ptr < limit)
    else $error("blank fill pointer past its end");

  a_scroll_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCR_RD || state == ST_SCR_WR) |-> ptr < limit)
    else $error("scroll pointer past its end");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> 32'(ram_waddr) < 32'(CELL_COUNT))
    else $error("screen write outside memory");
`endif

endmodule

>>> verif/text_mode_console_writer_unit_tb.sv
// ----------------------------------------------------------------------------
// text_mode_console_writer_unit_tb
// Self-checking bench for the text console writer. A queue-fed driver offers
// write, clear, read and unused-mode requests under a series of screen
// geometries, scroll settings and attributes. An in-bench console model
// predicts every result, and a monitor compares each one field by field.
// Both sides idle at random. There is also one long receiver hold-off and one
// full drain in the middle of a phase.
// ----------------------------------------------------------------------------
module text_mode_console_writer_unit_tb;
  import tmcw_pkg::*;

  localparam int MAX_COLUMNS    = 80;
  localparam int MAX_ROWS       = 25;
  localparam int TAB_STOP       = 8;
  localparam int CELL_COUNT     = MAX_COLUMNS * MAX_ROWS;
  localparam int IDLE_PCT       = 8;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 20000;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CHAR_W-1:0] ch;
    logic [10:0]       ridx;
  } console_request_t;

  typedef struct packed {
    logic [CELL_W-1:0] entry;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              scrolled;
  } console_result_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               write_enable = 1'b0;
  logic [1:0]         write_index = REG_COLUMNS;
  logic [7:0]         write_data = 8'd0;
  logic               request_valid = 1'b0;
  logic               request_ready;
  logic [1:0]         mode = MODE_WRITE;
  logic [CHAR_W-1:0]  char_code = 8'd0;
  logic [10:0]        read_index = 11'd0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  logic [CELL_W-1:0]  cell_entry;
  logic [ROW_W-1:0]   cursor_row;
  logic [COL_W-1:0]   cursor_col;
  logic               scrolled;

  console_request_t pending_requests[$];
  console_result_t  expected_results[$];
  int               issued_count = 0;
  int               accepted_count = 0;
  int               error_count = 0;
  int               idle_cycles = 0;
  int               hold_count = 0;
  bit               no_idle = 1'b0;
  bit               long_stall_req = 1'b0;
  bit               long_stall_done = 1'b0;

  // console model state
  logic [CELL_W-1:0] screen_image [0:CELL_COUNT-1];
  int                cur_row = 0;
  int                cur_col = 0;
  int                cfg_cols = 80;
  int                cfg_rows = 25;
  bit                cfg_scroll = 1'b0;
  logic [ATTR_W-1:0] cfg_attr = 8'h07;

  text_mode_console_writer_unit #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS(MAX_ROWS),
    .TAB_STOP(TAB_STOP)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .write_enable(write_enable),
    .write_index(write_index),
    .write_data(write_data),
    .request_valid(request_valid),
    .request_ready(request_ready),
    .mode(mode),
    .char_code(char_code),
    .read_index(read_index),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .cell_entry(cell_entry),
    .cursor_row(cursor_row),
    .cursor_col(cursor_col),
    .scrolled(scrolled)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int active_columns();
    int c;
    c = cfg_cols;
    if (c < 1) c = 1;
    if (c > MAX_COLUMNS) c = MAX_COLUMNS;
    return c;
  endfunction

  function automatic int active_rows();
    int r;
    r = cfg_rows;
    if (r < 1) r = 1;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return r;
  endfunction

  function automatic void store_cell(int index, logic [CHAR_W-1:0] ch);
    if (index < CELL_COUNT) screen_image[index] = {cfg_attr, ch};
  endfunction

  function automatic bit wrap_cursor();
    int cols;
    int rows;
    int kept;
    cols = active_columns();
    rows = active_rows();
    if (cur_col >= cols) begin
      cur_row++;
      cur_col = 0;
    end
    if (cur_row >= rows) begin
      if (cfg_scroll) begin
        kept = cols * (rows - 1);
        for (int i = 0; i < kept; i++) screen_image[i] = screen_image[i + cols];
        for (int i = 0; i < cols; i++) store_cell(kept + i, CHAR_BLANK);
        cur_row = rows - 1;
        return 1'b1;
      end
      cur_row = 0;
    end
    return 1'b0;
  endfunction

  function automatic console_result_t console_step(logic [1:0] op, logic [CHAR_W-1:0] ch,
                                                   logic [10:0] ridx);
    console_result_t res;
    int n;
    res = '0;
    case (op)
      MODE_WRITE: begin
        case (ch)
          CHAR_LF: begin
            cur_row++;
            cur_col = 0;
            res.scrolled = wrap_cursor();
          end
          CHAR_VT, CHAR_FF: begin
            cur_row++;
            res.scrolled = wrap_cursor();
          end
          CHAR_CR: cur_col = 0;
          CHAR_TAB: begin
            cur_col += TAB_STOP - (cur_col % TAB_STOP);
            res.scrolled = wrap_cursor();
          end
          default: begin
            store_cell(cur_row * active_columns() + cur_col, ch);
            cur_col++;
            res.scrolled = wrap_cursor();
          end
        endcase
      end
      MODE_CLEAR: begin
        n = active_columns() * active_rows();
        for (int i = 0; i < n; i++) store_cell(i, CHAR_BLANK);
      end
      MODE_READ: begin
        if (ridx < CELL_COUNT) res.entry = screen_image[ridx];
      end
      default: ;
    endcase
    res.row = cur_row[ROW_W-1:0];
    res.col = cur_col[COL_W-1:0];
    return res;
  endfunction

  function automatic console_request_t random_request();
    console_request_t req;
    int pick;
    int span;
    span = active_columns() * active_rows();
    req.mode = MODE_WRITE;
    req.ch = 8'($urandom_range(255));
    req.ridx = 11'($urandom_range(2047));
    pick = $urandom_range(99);
    if (pick < 3) begin
      req.mode = MODE_CLEAR;
    end else if (pick < 17) begin
      req.mode = MODE_READ;
      if ($urandom_range(9) != 0) req.ridx = 11'($urandom_range(span - 1));
    end else if (pick < 19) begin
      req.mode = MODE_UNUSED;
    end else if (pick < 31) begin
      case ($urandom_range(4))
        0: req.ch = CHAR_TAB;
        1: req.ch = CHAR_LF;
        2: req.ch = CHAR_VT;
        3: req.ch = CHAR_FF;
        default: req.ch = CHAR_CR;
      endcase
    end else if (pick < 70) begin
      req.ch = 8'($urandom_range(8'h7E, 8'h20));
    end
    return req;
  endfunction

  task automatic report_error(string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic queue_request(logic [1:0] op, logic [CHAR_W-1:0] ch, logic [10:0] ridx);
    console_request_t req;
    req.mode = op;
    req.ch = ch;
    req.ridx = ridx;
    pending_requests.push_back(req);
    issued_count++;
  endtask

  task automatic wait_idle();
    while (accepted_count != issued_count || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(int cols, int rows, bit scroll_on, logic [ATTR_W-1:0] attr);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index <= REG_COLUMNS;
    write_data <= 8'(cols);
    @(posedge clk);
    write_index <= REG_ROWS;
    write_data <= 8'(rows);
    @(posedge clk);
    write_index <= REG_SCROLL;
    write_data <= {7'd0, scroll_on};
    @(posedge clk);
    write_index <= REG_ATTRIBUTE;
    write_data <= attr;
    @(posedge clk);
    write_enable <= 1'b0;
    cfg_cols = cols & 127;
    cfg_rows = rows & 31;
    cfg_scroll = scroll_on;
    cfg_attr = attr;
  endtask

  task automatic queue_random(int count);
    console_request_t req;
    repeat (count) begin
      req = random_request();
      queue_request(req.mode, req.ch, req.ridx);
    end
  endtask

  task automatic run_phase(int cols, int rows, bit scroll_on, logic [ATTR_W-1:0] attr,
                           int count, int line_feeds);
    apply_setting(cols, rows, scroll_on, attr);
    repeat (line_feeds) queue_request(MODE_WRITE, CHAR_LF, 11'($urandom_range(2047)));
    queue_random(count);
    wait_idle();
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    console_request_t req;
    if (rst) begin
      request_valid <= 1'b0;
    end else begin
      if (request_valid && request_ready) begin
        expected_results.push_back(console_step(mode, char_code, read_index));
        accepted_count++;
      end
      if (!request_valid || request_ready) begin
        if (pending_requests.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          req = pending_requests.pop_front();
          request_valid <= 1'b1;
          mode <= req.mode;
          char_code <= req.ch;
          read_index <= req.ridx;
        end else begin
          request_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    console_result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("result with nothing pending, row %0d col %0d",
                                 cursor_row, cursor_col));
        end else begin
          want = expected_results.pop_front();
          if (cell_entry !== want.entry)
            report_error($sformatf("cell_entry got %h want %h", cell_entry, want.entry));
          if (cursor_row !== want.row)
            report_error($sformatf("cursor_row got %0d want %0d", cursor_row, want.row));
          if (cursor_col !== want.col)
            report_error($sformatf("cursor_col got %0d want %0d", cursor_col, want.col));
          if (scrolled !== want.scrolled)
            report_error($sformatf("scrolled got %b want %b", scrolled, want.scrolled));
        end
      end
      if (long_stall_req && !long_stall_done) begin
        hold_count++;
        if (hold_count >= LONG_HOLD) long_stall_done = 1'b1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((request_valid && request_ready) || (result_valid && result_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("text_mode_console_writer_unit_tb failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // clear first so no cell is ever read unwritten
    queue_request(MODE_CLEAR, 8'h00, 11'd0);
    queue_request(MODE_WRITE, 8'h00, 11'd0);
    queue_request(MODE_WRITE, 8'hFF, 11'h7FF);
    queue_request(MODE_WRITE, 8'h41, 11'd0);
    queue_request(MODE_READ, 8'h00, 11'd0);
    queue_request(MODE_READ, 8'hFF, 11'd1);
    queue_request(MODE_READ, 8'h00, 11'd2);
    queue_request(MODE_WRITE, CHAR_TAB, 11'd0);
    queue_request(MODE_WRITE, 8'h41, 11'd0);
    queue_request(MODE_WRITE, CHAR_LF, 11'd0);
    queue_request(MODE_WRITE, CHAR_VT, 11'd0);
    queue_request(MODE_WRITE, CHAR_FF, 11'd0);
    queue_request(MODE_WRITE, CHAR_CR, 11'd0);
    queue_request(MODE_WRITE, CHAR_BLANK, 11'd0);
    queue_request(MODE_READ, 8'h00, 11'd1999);
    queue_request(MODE_READ, 8'h00, 11'd2000);
    queue_request(MODE_READ, 8'h00, 11'h7FF);
    queue_request(MODE_UNUSED, 8'hFF, 11'h7FF);
    queue_request(MODE_CLEAR, 8'hFF, 11'h7FF);
    queue_request(MODE_READ, 8'h00, 11'd5);
    wait_idle();

    run_phase(80, 25, 1'b1, 8'h1F, 120, 30);
    run_phase(127, 31, 1'b1, 8'hA5, 100, 0);
    no_idle = 1'b1;
    run_phase(10, 5, 1'b1, 8'h3C, 200, 0);
    no_idle = 1'b0;
    run_phase(1, 1, 1'b1, 8'hFF, 150, 0);
    run_phase(0, 0, 1'b0, 8'h00, 100, 0);

    // receiver hold-off while the sender keeps offering, then a full drain
    apply_setting(17, 3, 1'b0, 8'h5A);
    long_stall_req = 1'b1;
    queue_random(100);
    wait_idle();
    queue_random(100);
    wait_idle();

    run_phase(40, 12, 1'b1, 8'hC3, 200, 0);
    run_phase(8, 25, 1'b0, 8'h70, 150, 0);
    run_phase(80, 1, 1'b1, 8'h0F, 150, 0);
    repeat (3)
      run_phase($urandom_range(80, 1), $urandom_range(25, 1), 1'($urandom_range(1)),
                8'($urandom_range(255)), 60, 0);

    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0)
      $display("text_mode_console_writer_unit_tb passed");
    else
      $display("text_mode_console_writer_unit_tb failed");
    $finish;
  end

endmodule

>>> filelist.f
src/tmcw_pkg.sv
src/tmcw_ram.sv
src/tmcw_cursor.sv
src/text_mode_console_writer_unit.sv
verif/text_mode_console_writer_unit_tb.sv
